### hw/rtl/cmdv_pkg.sv
`timescale 1ns / 1ps
// Package for the command argument token validator.
// Type codes, character constants, payload structs and character class functions.
// No dependencies.
package cmdv_pkg;

   localparam int COUNT_WIDTH_DEF = 8;
   localparam int DIGITS_W        = 5;
   localparam int LEN_W           = 8;

   localparam logic [DIGITS_W-1:0] MAX_DIGITS_RST = 5'd19;

   // Token type codes; codes 6 and 7 behave as free-form.
   localparam logic [2:0] TC_UNSIGNED = 3'd0;
   localparam logic [2:0] TC_SIGNED   = 3'd1;
   localparam logic [2:0] TC_DECIMAL  = 3'd2;
   localparam logic [2:0] TC_HEX      = 3'd3;
   localparam logic [2:0] TC_BASE64   = 3'd4;
   localparam logic [2:0] TC_FREE     = 3'd5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      logic [2:0] tok_kind;
      logic [7:0] char_code;
      logic       first;
      logic       last;
      logic       empty_req;
   } item_type;

   typedef struct packed {
      logic             accept;
      logic [LEN_W-1:0] token_length;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_b64(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             is_digit(c) || (c == CH_PLUS) || (c == CH_SLASH) || (c == CH_MINUS) ||
             (c == CH_UNDER) || (c == CH_EQ);
   endfunction

endpackage

### hw/rtl/cmdv_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the token validator.
// Depends on nothing; field widths follow the payload definition.
interface cmdv_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] tok_kind;
   logic [7:0] char_code;
   logic       first;
   logic       last;
   logic       empty_req;

   modport source (output valid, tok_kind, char_code, first, last, empty_req,
                   input ready);
   modport sink   (input valid, tok_kind, char_code, first, last, empty_req,
                   output ready);
endinterface

interface cmdv_rsp_if;
   logic       valid;
   logic       ready;
   logic       accept;
   logic [7:0] token_length;

   modport source (output valid, accept, token_length, input ready);
   modport sink   (input valid, accept, token_length, output ready);
endinterface

### hw/rtl/cmdv_tok_check.sv
`timescale 1ns / 1ps
// Per-token state and character rules of the token validator.
// Depends on cmdv_pkg.
module cmdv_tok_check
   import cmdv_pkg::*;
#(
   parameter int CountWidth = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  item_type            item,
   input  logic [DIGITS_W-1:0] max_digits,
   output result_type          result
);

   localparam int WideW = (CountWidth > LEN_W) ? CountWidth : LEN_W + 1;

   logic [2:0]            held_type_ff, held_type_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  dot_ff, dot_in;
   logic                  odd_ff, odd_in;
   logic [1:0]            quart_ff, quart_in;
   logic                  valid_ff, valid_in;

   logic [2:0]            b_type;
   logic [CountWidth-1:0] b_count, n_count;
   logic                  b_dot, b_odd, b_valid;
   logic [1:0]            b_quart;
   logic                  n_dot, n_odd, n_valid, ok, at_start, verdict;
   logic [1:0]            n_quart;
   logic [WideW-1:0]      count_wide, max_wide;
   logic [7:0]            c;

   // first discards any unfinished token
   always_comb begin
      b_type  = item.first ? item.tok_kind : held_type_ff;
      b_count = item.first ? '0 : count_ff;
      b_dot   = item.first ? 1'b0 : dot_ff;
      b_odd   = item.first ? 1'b0 : odd_ff;
      b_quart = item.first ? 2'd0 : quart_ff;
      b_valid = item.first ? 1'b1 : valid_ff;
   end

   assign c        = item.char_code;
   assign at_start = (b_count == '0);

   always_comb begin
      ok      = 1'b1;
      n_dot   = b_dot;
      n_odd   = b_odd;
      n_quart = b_quart;
      if (!item.empty_req) begin
         unique case (b_type)
            TC_UNSIGNED: ok = is_digit(c);
            TC_SIGNED:   ok = (at_start && (c == CH_MINUS)) || is_digit(c);
            TC_DECIMAL: begin
               priority if (at_start && (c == CH_MINUS)) begin
                  ok = 1'b1;
               end else if ((c == CH_DOT) && !b_dot && !at_start && !item.last) begin
                  n_dot = 1'b1;
               end else begin
                  ok = is_digit(c);
               end
            end
            TC_HEX: begin
               priority if ((c == CH_SPACE) || (c == CH_UNDER)) begin
                  ok = !b_odd;
               end else if (is_hex(c)) begin
                  n_odd = !b_odd;
               end else begin
                  ok = 1'b0;
               end
            end
            TC_BASE64: begin
               priority if (c == CH_SPACE) begin
                  ok = (b_quart == 2'd0);
               end else if (is_b64(c)) begin
                  n_quart = b_quart + 2'd1;
               end else begin
                  ok = 1'b0;
               end
            end
            default: ok = 1'b1;
         endcase
      end
   end

   assign n_valid = b_valid && ok;
   assign n_count = (item.empty_req || (b_count == '1)) ? b_count
                                                          : b_count + CountWidth'(1);

   assign count_wide = WideW'(n_count);
   assign max_wide   = WideW'(max_digits);

   always_comb begin
      unique case (b_type)
         TC_UNSIGNED: verdict = n_valid && (n_count != '0) && (count_wide <= max_wide);
         TC_SIGNED,
         TC_DECIMAL:  verdict = n_valid && (n_count != '0);
         TC_HEX:      verdict = n_valid && !n_odd;
         TC_BASE64:   verdict = n_valid && (n_quart == 2'd0);
         default:     verdict = 1'b1;
      endcase
   end

   assign result.accept       = verdict;
   assign result.token_length = (count_wide > WideW'(255)) ? 8'hFF : count_wide[LEN_W-1:0];

   // after a result the flags clear and the type is kept
   always_comb begin
      held_type_in = held_type_ff;
      count_in     = count_ff;
      dot_in       = dot_ff;
      odd_in       = odd_ff;
      quart_in     = quart_ff;
      valid_in     = valid_ff;
      if (step) begin
         held_type_in = b_type;
         if (item.last) begin
            count_in = '0;
            dot_in   = 1'b0;
            odd_in   = 1'b0;
            quart_in = 2'd0;
            valid_in = 1'b1;
         end else begin
            count_in = n_count;
            dot_in   = n_dot;
            odd_in   = n_odd;
            quart_in = n_quart;
            valid_in = n_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_type_ff <= TC_UNSIGNED;
         count_ff     <= '0;
         dot_ff       <= 1'b0;
         odd_ff       <= 1'b0;
         quart_ff     <= 2'd0;
         valid_ff     <= 1'b1;
      end else begin
         held_type_ff <= held_type_in;
         count_ff     <= count_in;
         dot_ff       <= dot_in;
         odd_ff       <= odd_in;
         quart_ff     <= quart_in;
         valid_ff     <= valid_in;
      end
   end

   // a finished token leaves no leftover flags behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> (count_ff == '0) && valid_ff && !odd_ff && (quart_ff == 2'd0))
      else $error("token state not cleared after last item");

   // count only grows by one per character within a token
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      step && !item.first && !item.last && !item.empty_req && (count_ff != '1)
      |=> count_ff == $past(count_ff) + CountWidth'(1))
      else $error("character count did not advance");

   // odd nibble is only ever set for hex tokens
   a_odd_hex_only: assert property (@(posedge clock) disable iff (reset)
      odd_ff |-> held_type_ff == TC_HEX)
      else $error("odd nibble flag outside hex token");

endmodule

### hw/rtl/cmdv_out_reg.sv
`timescale 1ns / 1ps
// Result register of the token validator, drives the response channel.
// Depends on cmdv_pkg and cmdv_rsp_if.
module cmdv_out_reg
   import cmdv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  result_type        result,
   output logic              room,
   cmdv_rsp_if.source        rsp
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign room     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);
   assign data_in  = load ? result : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.accept       = data_ff.accept;
   assign rsp.token_length = data_ff.token_length;

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> room)
      else $error("result register loaded while full");

endmodule

### hw/rtl/command_argument_token_validator.sv
`timescale 1ns / 1ps
// Top level of the command argument token validator.
// Depends on cmdv_pkg, cmdv_if, cmdv_tok_check and cmdv_out_reg.
//
//  channel   direction  carries
//  req_ch    in         tok_kind, char_code, first, last, empty_req (one char)
//  rsp_ch    out        accept, token_length (one per token, on last)
//  csr_*     in         max_unsigned_digits, written when csr_we is high
//
// One character per cycle, sustained while no last item waits on rsp_ch. A
// transfer on req_ch lands in the input register; from there the token check
// updates its flags and, for a last item, loads the result register, which
// drives rsp_ch.valid (two registers deep). Items that are not last never
// wait on rsp_ch; a last item waits in the input register while an earlier
// result is still untaken, and req_ch.ready then follows rsp_ch.ready.
// Synchronous reset clears the token state, empties both registers and sets
// the digit limit to 19.
module command_argument_token_validator
   import cmdv_pkg::*;
#(
   parameter int CountWidth = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   cmdv_req_if.sink            req_ch,
   cmdv_rsp_if.source          rsp_ch,
   input  logic                csr_we,
   input  logic [DIGITS_W-1:0] csr_wdata
);

   // digit limit for unsigned tokens
   logic [DIGITS_W-1:0] max_digits_ff, max_digits_in;

   // input register
   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff, in_item_in, req_item;

   logic       advance;   // input register item is processed this cycle
   logic       out_room;  // result register can take a result
   logic       req_xfer;
   result_type result;

   assign max_digits_in = csr_we ? csr_wdata : max_digits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_digits_ff <= MAX_DIGITS_RST;
      end else begin
         max_digits_ff <= max_digits_in;
      end
   end

   // only a last item needs space downstream
   assign advance      = in_valid_ff && (!in_item_ff.last || out_room);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign req_item.tok_kind  = req_ch.tok_kind;
   assign req_item.char_code = req_ch.char_code;
   assign req_item.first     = req_ch.first;
   assign req_item.last      = req_ch.last;
   assign req_item.empty_req = req_ch.empty_req;

   assign in_valid_in = req_xfer || (in_valid_ff && !advance);
   assign in_item_in  = req_xfer ? req_item : in_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   cmdv_tok_check #(
      .CountWidth (CountWidth)
   ) u_tok_check (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .max_digits (max_digits_ff),
      .result     (result)
   );

   cmdv_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && in_item_ff.last),
      .result (result),
      .room   (out_room),
      .rsp    (rsp_ch)
   );

   // a waiting item is never dropped
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input item lost");

   // a transfer into a full input register only when it moves on
   a_fill_ok: assert property (@(posedge clock) disable iff (reset)
      req_xfer && in_valid_ff |-> advance)
      else $error("input register overrun");

   // a last item stalls only behind an untaken result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> rsp_ch.valid && !rsp_ch.ready && in_item_ff.last)
      else $error("input stalled without cause");

endmodule
